// ----- src/srso_pkg.sv -----
package srso_pkg;

    // widths fixed by the item and register definitions
    localparam int COUNT_W      = 32;
    localparam int SLOT_W       = 3;
    localparam int ORDER_W      = 2;
    localparam int ORDER_FIELDS = 4;
    localparam int CFG_IDX_W    = 1;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [ORDER_W-1:0] order_t;

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SUCCESS = 2'd1,
        KIND_ADJUST  = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL_TICKS = 1'd0,
        REG_MIN_SHARES     = 1'd1
    } cfg_reg_t;

    // register reset values
    localparam count_t INTERVAL_TICKS_RESET = count_t'(3 * 60 * 1000);
    localparam count_t MIN_SHARES_RESET     = count_t'(50);

endpackage

// ----- src/srso_in_if.sv -----
interface srso_in_if;

    logic               valid;
    logic               ready;
    srso_pkg::kind_t    kind;
    srso_pkg::slot_t    slot_index;

    modport source (output valid, output kind, output slot_index, input ready);
    modport sink   (input valid, input kind, input slot_index, output ready);

endinterface

// ----- src/srso_out_if.sv -----
interface srso_out_if;

    logic               valid;
    logic               ready;
    srso_pkg::order_t   order_first;
    srso_pkg::order_t   order_second;
    srso_pkg::order_t   order_third;
    srso_pkg::order_t   order_fourth;
    logic               adjusted;
    logic               order_changed;

    modport source (
        output valid, output order_first, output order_second, output order_third,
        output order_fourth, output adjusted, output order_changed, input ready
    );
    modport sink (
        input valid, input order_first, input order_second, input order_third,
        input order_fourth, input adjusted, input order_changed, output ready
    );

endinterface

// ----- src/srso_cfg_if.sv -----
interface srso_cfg_if;

    logic                   valid;
    logic                   ready;
    srso_pkg::cfg_reg_t     index;
    srso_pkg::count_t       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ----- src/success_ranked_slot_order.sv -----
// channel  direction  transaction
// req      in         kind, slot_index
// rsp      out        order_first..order_fourth, adjusted, order_changed
// cfg      in         index, data (register write, always ready)
//
// one item per cycle unless req stalls: the statistics, the order and the output
// register all update at the edge that accepts an item
// the whole rank network is one combinational pass between the state
// registers and the output register
// reset clears statistics, order and registers to their defaults
// req stalls only while a result waits in the output register and rsp is not ready
module success_ranked_slot_order #(
    parameter int NUM_SLOTS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    srso_in_if.sink         req,
    srso_out_if.source      rsp,
    srso_cfg_if.sink        cfg
);

    localparam int IDX_W = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;

    typedef logic [IDX_W-1:0] idx_t;

    // configuration registers
    srso_pkg::count_t interval_reg;
    srso_pkg::count_t min_shares_reg;

    // statistics and order
    srso_pkg::count_t count_reg [NUM_SLOTS];
    srso_pkg::count_t count_next [NUM_SLOTS];
    srso_pkg::count_t total_reg;
    srso_pkg::count_t total_next;
    srso_pkg::count_t elapsed_reg;
    srso_pkg::count_t elapsed_next;
    idx_t             order_reg [NUM_SLOTS];
    idx_t             order_next [NUM_SLOTS];

    // output register
    logic             rsp_valid_reg;
    srso_pkg::order_t rsp_order_reg [srso_pkg::ORDER_FIELDS];
    srso_pkg::order_t rsp_order_next [srso_pkg::ORDER_FIELDS];
    logic             rsp_adjusted_reg;
    logic             rsp_adjusted_next;
    logic             rsp_changed_reg;
    logic             rsp_changed_next;

    // rank network signals
    idx_t             rank_idx [NUM_SLOTS];
    srso_pkg::count_t rank_cnt [NUM_SLOTS];
    logic             rank_differs;
    logic             adjust_due;
    logic             slot_ok;
    logic             accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // exchange sort from the identity order, counts travel with their slot
    always_comb
    begin
        idx_t             tmp_idx;
        srso_pkg::count_t tmp_cnt;
        tmp_idx = '0;
        tmp_cnt = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            rank_idx[k] = idx_t'(k);
            rank_cnt[k] = count_reg[k];
        end
        for (int i = 0; i < NUM_SLOTS - 1; i++)
        begin
            for (int j = i + 1; j < NUM_SLOTS; j++)
            begin
                if (rank_cnt[j] > rank_cnt[i])
                begin
                    tmp_idx     = rank_idx[i];
                    tmp_cnt     = rank_cnt[i];
                    rank_idx[i] = rank_idx[j];
                    rank_cnt[i] = rank_cnt[j];
                    rank_idx[j] = tmp_idx;
                    rank_cnt[j] = tmp_cnt;
                end
            end
        end
    end

    // new order against the current one
    always_comb
    begin
        rank_differs = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (rank_idx[k] != order_reg[k])
            begin
                rank_differs = 1'b1;
            end
        end
    end

    assign adjust_due = (elapsed_reg >= interval_reg) || (total_reg >= min_shares_reg);
    assign slot_ok    = ({1'b0, req.slot_index} < (srso_pkg::SLOT_W + 1)'(NUM_SLOTS));

    // next state for the item on req
    always_comb
    begin
        count_next        = count_reg;
        total_next        = total_reg;
        elapsed_next      = elapsed_reg;
        order_next        = order_reg;
        rsp_adjusted_next = 1'b0;
        rsp_changed_next  = 1'b0;
        case (req.kind)
            srso_pkg::KIND_TICK:
            begin
                if (elapsed_reg != '1)
                begin
                    elapsed_next = elapsed_reg + srso_pkg::count_t'(1);
                end
            end
            srso_pkg::KIND_SUCCESS:
            begin
                if (slot_ok)
                begin
                    count_next[req.slot_index[IDX_W-1:0]] =
                        count_reg[req.slot_index[IDX_W-1:0]] + srso_pkg::count_t'(1);
                    total_next = total_reg + srso_pkg::count_t'(1);
                end
            end
            srso_pkg::KIND_ADJUST:
            begin
                if (adjust_due)
                begin
                    order_next        = rank_idx;
                    for (int k = 0; k < NUM_SLOTS; k++)
                    begin
                        count_next[k] = '0;
                    end
                    total_next        = '0;
                    elapsed_next      = '0;
                    rsp_adjusted_next = 1'b1;
                    rsp_changed_next  = rank_differs;
                end
            end
            srso_pkg::KIND_CLEAR:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    count_next[k] = '0;
                end
                total_next = '0;
            end
            default:
            begin
                total_next = total_reg;
            end
        endcase
    end

    // order fields after the item, positions past the slot count stay identity
    for (genvar k = 0; k < srso_pkg::ORDER_FIELDS; k++)
    begin : g_order_out
        if (k < NUM_SLOTS)
        begin : g_slot
            logic [7:0] wide;
            assign wide              = 8'(order_next[k]);
            assign rsp_order_next[k] = wide[srso_pkg::ORDER_W-1:0];
        end
        else
        begin : g_fixed
            assign rsp_order_next[k] = srso_pkg::order_t'(k);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= srso_pkg::INTERVAL_TICKS_RESET;
            min_shares_reg <= srso_pkg::MIN_SHARES_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                srso_pkg::REG_INTERVAL_TICKS: interval_reg   <= cfg.data;
                srso_pkg::REG_MIN_SHARES:     min_shares_reg <= cfg.data;
                default:                      interval_reg   <= interval_reg;
            endcase
        end
    end

    // statistics and order state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                count_reg[k] <= '0;
                order_reg[k] <= idx_t'(k);
            end
            total_reg   <= '0;
            elapsed_reg <= '0;
        end
        else if (accept)
        begin
            count_reg   <= count_next;
            order_reg   <= order_next;
            total_reg   <= total_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= req.valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_order_reg    <= rsp_order_next;
            rsp_adjusted_reg <= rsp_adjusted_next;
            rsp_changed_reg  <= rsp_changed_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.order_first   = rsp_order_reg[0];
    assign rsp.order_second  = rsp_order_reg[1];
    assign rsp.order_third   = rsp_order_reg[2];
    assign rsp.order_fourth  = rsp_order_reg[3];
    assign rsp.adjusted      = rsp_adjusted_reg;
    assign rsp.order_changed = rsp_changed_reg;

endmodule

// ----- tb/sv/success_ranked_slot_order_tb.sv -----
`timescale 1ns / 100ps

module success_ranked_slot_order_tb;

    localparam int               NUM_SLOTS    = 4;
    localparam int               IDLE_LIMIT   = 1000;
    localparam int               HOLD_CYCLES  = 150;
    localparam int               DRAIN_CYCLES = 10;
    localparam srso_pkg::count_t COUNT_MAX    = '1;

    typedef struct packed {
        srso_pkg::order_t first;
        srso_pkg::order_t second;
        srso_pkg::order_t third;
        srso_pkg::order_t fourth;
        logic             adjusted;
        logic             order_changed;
    } slot_result_t;

    logic clk;
    logic rst_n;

    srso_in_if  req_if ();
    srso_out_if rsp_if ();
    srso_cfg_if cfg_if ();

    success_ranked_slot_order #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // predicted block state
    srso_pkg::count_t shares [NUM_SLOTS];
    srso_pkg::count_t share_sum;
    srso_pkg::count_t ticks_seen;
    srso_pkg::order_t service_order [NUM_SLOTS];
    srso_pkg::count_t interval_reg;
    srso_pkg::count_t min_shares_reg;

    // orders still owed by the block, oldest first
    slot_result_t order_q [$];

    int fail_count    = 0;
    int send_gap_pct  = 30;
    int stall_pct     = 20;
    int hold_request  = 0;
    int idle_cycles   = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void clear_shares();
        for (int k = 0; k < NUM_SLOTS; k++)
            shares[k] = '0;
        share_sum = '0;
    endfunction

    // apply one accepted item to the predicted state and queue its order
    task automatic predict_order(input srso_pkg::kind_t kind, input srso_pkg::slot_t slot);
        srso_pkg::order_t ranked [NUM_SLOTS];
        srso_pkg::order_t swap_tmp;
        slot_result_t     res;
        res = '0;
        case (kind)
            srso_pkg::KIND_TICK:
                if (ticks_seen != COUNT_MAX)
                    ticks_seen++;
            srso_pkg::KIND_SUCCESS:
                if (slot < NUM_SLOTS)
                begin
                    shares[slot]++;
                    share_sum++;
                end
            srso_pkg::KIND_ADJUST:
                if (ticks_seen >= interval_reg || share_sum >= min_shares_reg)
                begin
                    // exchange sort from the identity order, strict compare
                    for (int i = 0; i < NUM_SLOTS; i++)
                        ranked[i] = srso_pkg::order_t'(i);
                    for (int i = 0; i < NUM_SLOTS - 1; i++)
                        for (int j = i + 1; j < NUM_SLOTS; j++)
                            if (shares[ranked[j]] > shares[ranked[i]])
                            begin
                                swap_tmp  = ranked[i];
                                ranked[i] = ranked[j];
                                ranked[j] = swap_tmp;
                            end
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (ranked[i] != service_order[i])
                            res.order_changed = 1'b1;
                    service_order = ranked;
                    clear_shares();
                    ticks_seen   = '0;
                    res.adjusted = 1'b1;
                end
            default:
                clear_shares();
        endcase
        res.first  = service_order[0];
        res.second = service_order[1];
        res.third  = service_order[2];
        res.fourth = service_order[3];
        order_q.push_back(res);
    endtask

    function automatic void check_field(input string name, input logic [1:0] want,
                                        input logic [1:0] seen);
        if (want !== seen)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endfunction

    // predictor: register writes and accepted input transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == srso_pkg::REG_INTERVAL_TICKS)
                    interval_reg = cfg_if.data;
                else
                    min_shares_reg = cfg_if.data;
            end
            if (req_if.valid && req_if.ready)
                predict_order(req_if.kind, req_if.slot_index);
        end
    end

    // checker: each output transaction against the oldest prediction
    always @(posedge clk)
    begin : check_result
        slot_result_t want;
        slot_result_t seen;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen = {rsp_if.order_first, rsp_if.order_second, rsp_if.order_third,
                    rsp_if.order_fourth, rsp_if.adjusted, rsp_if.order_changed};
            if (order_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            end
            else
            begin
                want = order_q.pop_front();
                check_field("order_first",   want.first,         seen.first);
                check_field("order_second",  want.second,        seen.second);
                check_field("order_third",   want.third,         seen.third);
                check_field("order_fourth",  want.fourth,        seen.fourth);
                check_field("adjusted",      want.adjusted,      seen.adjusted);
                check_field("order_changed", want.order_changed, seen.order_changed);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls, plus a long hold when one is requested
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = gap_length();
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // offer one item and wait for its transaction; valid stays up unless a gap follows
    task automatic send_item(input srso_pkg::kind_t kind, input srso_pkg::slot_t slot);
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.slot_index <= slot;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            req_if.valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    // stop sending until every predicted order has come back
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (order_q.size() != 0);
    endtask

    // write both thresholds while the block is idle
    task automatic write_thresholds(input srso_pkg::count_t interval,
                                    input srso_pkg::count_t min_shares);
        wait_for_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= srso_pkg::REG_INTERVAL_TICKS;
        cfg_if.data  <= interval;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.index <= srso_pkg::REG_MIN_SHARES;
        cfg_if.data  <= min_shares;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // reset thresholds: a fresh block is not yet due
    task automatic test_defaults_not_due();
        send_item(srso_pkg::KIND_SUCCESS, 3'd0);
        send_item(srso_pkg::KIND_ADJUST, 3'd0);
    endtask

    // slot indexes 1 to 7, the ignored ones included, then tick and clear
    task automatic test_slot_range();
        for (int s = 1; s < 8; s++)
            send_item(srso_pkg::KIND_SUCCESS, srso_pkg::slot_t'(s));
        send_item(srso_pkg::KIND_TICK, 3'd7);
        send_item(srso_pkg::KIND_CLEAR, 3'd5);
    endtask

    // share minimum reached with the interval at its maximum
    task automatic test_rank_by_shares();
        write_thresholds(COUNT_MAX, 32'd3);
        send_item(srso_pkg::KIND_SUCCESS, 3'd3);
        send_item(srso_pkg::KIND_SUCCESS, 3'd3);
        send_item(srso_pkg::KIND_SUCCESS, 3'd2);
        send_item(srso_pkg::KIND_ADJUST, 3'd6);
    endtask

    // zero thresholds: every adjust acts, ties keep the identity order
    task automatic test_zero_thresholds();
        write_thresholds('0, '0);
        send_item(srso_pkg::KIND_ADJUST, 3'd0);
        send_item(srso_pkg::KIND_ADJUST, 3'd4);
    endtask

    // interval of one tick; clearing statistics keeps the elapsed count
    task automatic test_tick_interval();
        write_thresholds(32'd1, COUNT_MAX);
        send_item(srso_pkg::KIND_ADJUST, 3'd0);
        send_item(srso_pkg::KIND_TICK, 3'd0);
        send_item(srso_pkg::KIND_ADJUST, 3'd1);
        send_item(srso_pkg::KIND_TICK, 3'd2);
        send_item(srso_pkg::KIND_SUCCESS, 3'd2);
        send_item(srso_pkg::KIND_CLEAR, 3'd0);
        send_item(srso_pkg::KIND_ADJUST, 3'd0);
    endtask

    // random item, biased towards successes on a favoured slot
    task automatic send_random_item(input int favourite);
        int              pick;
        srso_pkg::kind_t kind;
        srso_pkg::slot_t slot;
        pick = $urandom_range(0, 99);
        slot = srso_pkg::slot_t'($urandom_range(0, 7));
        if (pick < 55)
        begin
            kind = srso_pkg::KIND_SUCCESS;
            if ($urandom_range(0, 9) == 0)
                slot = srso_pkg::slot_t'($urandom_range(4, 7));
            else if ($urandom_range(0, 1) == 0)
                slot = srso_pkg::slot_t'(favourite);
            else
                slot = srso_pkg::slot_t'($urandom_range(0, 3));
        end
        else if (pick < 75)
            kind = srso_pkg::KIND_TICK;
        else if (pick < 92)
            kind = srso_pkg::KIND_ADJUST;
        else
            kind = srso_pkg::KIND_CLEAR;
        send_item(kind, slot);
    endtask

    // random phases, each with its own thresholds and idling
    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                1:       write_thresholds(COUNT_MAX, COUNT_MAX);
                3:       write_thresholds('0, '0);
                4:       write_thresholds(srso_pkg::count_t'($urandom),
                                          srso_pkg::count_t'($urandom));
                6:       write_thresholds(srso_pkg::INTERVAL_TICKS_RESET,
                                          srso_pkg::MIN_SHARES_RESET);
                default: write_thresholds(srso_pkg::count_t'($urandom_range(1, 12)),
                                          srso_pkg::count_t'($urandom_range(1, 12)));
            endcase
            send_gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 50);
            stall_pct    = (phase % 4 == 1) ? 0 : $urandom_range(10, 40);
            repeat (45) send_random_item($urandom_range(0, 3));
        end
    endtask

    // long receiver hold while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_thresholds(32'd4, 32'd5);
        send_gap_pct = 0;
        stall_pct    = 20;
        hold_request = HOLD_CYCLES;
        repeat (30) send_random_item($urandom_range(0, 3));
        wait_for_results();
    endtask

    // reset, tests in turn, then the final verdict
    initial
    begin
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.kind       <= srso_pkg::KIND_TICK;
        req_if.slot_index <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= srso_pkg::REG_INTERVAL_TICKS;
        cfg_if.data       <= '0;
        interval_reg   = srso_pkg::INTERVAL_TICKS_RESET;
        min_shares_reg = srso_pkg::MIN_SHARES_RESET;
        clear_shares();
        ticks_seen = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
            service_order[k] = srso_pkg::order_t'(k);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_not_due();
        test_slot_range();
        test_rank_by_shares();
        test_zero_thresholds();
        test_tick_interval();
        test_output_backpressure();
        test_random_phases();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (order_q.size() != 0)
        begin
            fail_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, order_q.size());
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
